@@ design/tod_pkg.sv @@
// Shared widths, reset values and register codes for the tilt orientation debouncer.
`timescale 1ns / 1ps

package tod_pkg;

  // Field widths
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned AVG_W      = 20;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Default timestamp width
  localparam int unsigned TIME_BITS_DEF = 32;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(3840);
  localparam logic [MS_W-1:0]  PERIOD_RESET = MS_W'(250);
  localparam logic [MS_W-1:0]  DWELL_RESET  = MS_W'(2000);

  // Filter arithmetic: 9*old + 16*pitch needs 24 signed bits, its magnitude 23
  localparam int unsigned SUM_W       = AVG_W + 4;
  localparam int unsigned MAG_W       = SUM_W - 1;
  localparam int unsigned DIV10_SHIFT = 26;
  localparam int unsigned PROD_W      = MAG_W + MAG_W;
  // ceil(2^26 / 10): exact quotient for every magnitude below 2^26 / 6
  localparam logic [MAG_W-1:0] DIV10_MUL = MAG_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILT_THRESHOLD = 2'd0,
    CFG_CHECK_PERIOD   = 2'd1,
    CFG_DWELL          = 2'd2
  } cfg_idx_e;

endpackage

@@ design/tod_if.sv @@
// Handshake channel interfaces: sample input, result output and register writes.
`timescale 1ns / 1ps

interface tod_in_if import tod_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [PITCH_W-1:0]   pitch_sample;
  logic        [TIME_BITS-1:0] now_ms;

  modport source (output valid, output pitch_sample, output now_ms, input ready);
  modport sink   (input valid, input pitch_sample, input now_ms, output ready);
endinterface

interface tod_out_if import tod_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    vertical_line;
  logic                    up_line;
  logic signed [AVG_W-1:0] smoothed_pitch;

  modport source (output valid, output vertical_line, output up_line,
                  output smoothed_pitch, input ready);
  modport sink   (input valid, input vertical_line, input up_line,
                  input smoothed_pitch, output ready);
endinterface

interface tod_cfg_if import tod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/tod_ema.sv @@
// Exponential average update: (9*old + 16*pitch) / 10, truncated toward zero.
`timescale 1ns / 1ps

module tod_ema import tod_pkg::*; (
  input  logic signed [AVG_W-1:0]   avg_old_i,
  input  logic signed [PITCH_W-1:0] pitch_i,
  output logic signed [AVG_W-1:0]   avg_new_o
);

  logic signed [SUM_W-1:0] old_x;
  logic signed [SUM_W-1:0] pitch_x;
  logic signed [SUM_W-1:0] sum;
  logic        [MAG_W-1:0] mag;
  logic        [PROD_W-1:0] prod;
  logic        [AVG_W-1:0] quo;

  assign old_x   = SUM_W'(avg_old_i);
  assign pitch_x = SUM_W'(pitch_i);
  assign sum     = (old_x <<< 3) + old_x + (pitch_x <<< 4);

  // divide the magnitude by ten through a reciprocal, then restore the sign
  assign mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign prod = PROD_W'(mag) * PROD_W'(DIV10_MUL);
  assign quo  = prod[DIV10_SHIFT +: AVG_W];

  assign avg_new_o = sum[SUM_W-1] ? (~quo + 1'b1) : quo;

endmodule

@@ design/tilt_orientation_debouncer_core.sv @@
// Top level of the tilt orientation debouncer: input stage, filter, classifier, result.
`timescale 1ns / 1ps

// Usage
//   in_i  : one word per pitch sample (1/128 degree) with its millisecond timestamp.
//   out_o : one word per input word: the two drive line levels after this sample and
//           the smoothed pitch in 1/2048 degree.
//   cfg_i : register writes (threshold, check period, dwell); always ready. Write only
//           while no sample is in flight.
// Path: a word accepted is held in the input stage; when the result register advances,
//   the filter and classifier run and load the result, and out_o.valid rises.
// Throughput: one word per cycle unless out_o.ready stalls. The filter state loops back
//   through one stage of logic (constant multiply, reciprocal divide by ten, compares),
//   so samples may follow each other back to back.
// Reset: the average, check and dwell timestamps, the class flag and both lines clear;
//   registers return to 3840, 250 ms and 2000 ms. No word is pending after reset.
// Stall: while out_o.ready is low the result holds; one more word may wait in the
//   input stage, after which in_i.ready drops.

module tilt_orientation_debouncer_core import tod_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tod_cfg_if.sink   cfg_i,
  tod_in_if.sink    in_i,
  tod_out_if.source out_o
);

  // configuration registers
  logic [THR_W-1:0] thr_q;
  logic [MS_W-1:0]  period_q;
  logic [MS_W-1:0]  dwell_q;

  // input stage
  logic                        s1_valid_q;
  logic signed [PITCH_W-1:0]   s1_pitch_q;
  logic        [TIME_BITS-1:0] s1_now_q;

  // filter and classifier state, doubling as the result register
  logic signed [AVG_W-1:0]     avg_q,   avg_d;
  logic        [TIME_BITS-1:0] last_q,  last_d;
  logic        [TIME_BITS-1:0] since_q, since_d;
  logic                        flag_q,  flag_d;
  logic                        vline_q, vline_d;
  logic                        up_q,    up_d;
  logic                        out_valid_q;

  logic                        advance;
  logic                        fire;
  logic [TIME_BITS-1:0]        check_gap;
  logic [TIME_BITS-1:0]        dwell_gap;
  logic                        check_due;
  logic                        dwell_done;
  logic signed [AVG_W:0]       avg_x;
  logic signed [AVG_W:0]       thr_x;
  logic                        above;
  logic                        below;

  // Register writes; unknown indexes drop.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      period_q <= PERIOD_RESET;
      dwell_q  <= DWELL_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TILT_THRESHOLD: thr_q    <= cfg_i.data[THR_W-1:0];
        CFG_CHECK_PERIOD:   period_q <= cfg_i.data[MS_W-1:0];
        CFG_DWELL:          dwell_q  <= cfg_i.data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register advances when empty or taken; the input stage
  // takes a word when empty or when its word moves on.
  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_pitch_q <= in_i.pitch_sample;
      s1_now_q   <= in_i.now_ms;
    end
  end

  // Filter arithmetic
  tod_ema u_ema (
    .avg_old_i (avg_q),
    .pitch_i   (s1_pitch_q),
    .avg_new_o (avg_d)
  );

  // Timestamp differences wrap in the timestamp width.
  assign check_gap  = s1_now_q - last_q;
  assign dwell_gap  = s1_now_q - since_q;
  assign check_due  = check_gap > TIME_BITS'(period_q);
  assign dwell_done = dwell_gap > TIME_BITS'(dwell_q);

  // Threshold scaled by 16 into the average's units.
  assign avg_x = (AVG_W + 1)'(avg_d);
  assign thr_x = {2'b00, thr_q, 4'b0000};
  assign above = avg_x > thr_x;
  assign below = avg_x < -thr_x;

  always_comb begin
    last_d  = last_q;
    since_d = since_q;
    flag_d  = flag_q;
    vline_d = vline_q;
    up_d    = up_q;
    if (check_due) begin
      last_d = s1_now_q;
      if (above || below) begin
        if (flag_q) begin
          // vertical held long enough: drive the vertical line, the up line only when tilted up
          if (dwell_done) begin
            vline_d = 1'b1;
            up_d    = above;
          end
        end else begin
          flag_d  = 1'b1;
          since_d = s1_now_q;
        end
      end else begin
        if (!flag_q) begin
          if (dwell_done) begin
            vline_d = 1'b0;
            up_d    = 1'b0;
          end
        end else begin
          flag_d  = 1'b0;
          since_d = s1_now_q;
        end
      end
    end
  end

  // State moves only as a word enters the result register, so the state itself
  // presents the result and holds through a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      last_q      <= '0;
      since_q     <= '0;
      flag_q      <= 1'b0;
      vline_q     <= 1'b0;
      up_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        avg_q   <= avg_d;
        last_q  <= last_d;
        since_q <= since_d;
        flag_q  <= flag_d;
        vline_q <= vline_d;
        up_q    <= up_d;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.vertical_line  = vline_q;
  assign out_o.up_line        = up_q;
  assign out_o.smoothed_pitch = avg_q;

endmodule

@@ design/tod_checker.sv @@
// Port-level checks for the tilt orientation debouncer and their binding.
`timescale 1ns / 1ps

module tod_checker import tod_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    vertical_line_i,
  input logic                    up_line_i,
  input logic signed [AVG_W-1:0] smoothed_pitch_i
);

  // The up line is only ever driven together with the vertical line.
  a_up_needs_vertical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (vertical_line_i || !up_line_i))
    else $error("up line high while vertical line low");

  // A word entered behind a stalled result, and the result is still stalled: input must block.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i && in_valid_i && in_ready_i) ##1
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input accepted with both stages full");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(vertical_line_i) &&
    $stable(up_line_i) && $stable(smoothed_pitch_i)))
    else $error("stalled result changed");

endmodule

bind tilt_orientation_debouncer_core tod_checker u_tod_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .vertical_line_i  (out_o.vertical_line),
  .up_line_i        (out_o.up_line),
  .smoothed_pitch_i (out_o.smoothed_pitch)
);
